>>> hw/rtl/cmpx_pkg.sv
// ============================================================================
// cmpx_pkg
// Shared codes and control types for the complex element-wise ALU.
// ============================================================================
`default_nettype none

package cmpx_pkg;

    // Operation codes
    localparam logic [3:0] OP_ADD     = 4'd0;
    localparam logic [3:0] OP_SUB     = 4'd1;
    localparam logic [3:0] OP_MUL     = 4'd2;
    localparam logic [3:0] OP_DIV     = 4'd3;
    localparam logic [3:0] OP_MULCONJ = 4'd4;
    localparam logic [3:0] OP_MAGSQ   = 4'd5;
    localparam logic [3:0] OP_ABS     = 4'd6;
    localparam logic [3:0] OP_CLIP    = 4'd7;
    localparam logic [3:0] OP_WADD    = 4'd8;
    localparam logic [3:0] OP_WMUL    = 4'd9;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DIV0  = 2'd1;
    localparam logic [1:0] ST_UNSUP = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CREAL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CIMAG  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 2'd3;

    // Per-item control carried out of the multiplier stage
    typedef struct packed {
        logic [3:0] op;
        logic       cmode;
    } ctl_t;

    // Divider bookkeeping carried along the cell row
    typedef struct packed {
        logic is_div;
        logic neg_r;
        logic neg_i;
        logic povf_r;
        logic povf_i;
    } dflag_t;

endpackage

`default_nettype wire

>>> hw/rtl/complex_elementwise_alu_unit.sv
// ============================================================================
// complex_elementwise_alu_unit
// Fixed-point complex/real element-wise ALU: add, sub, mul, div, conjugate
// multiply, magnitude squared, abs, clip, weighted add and weighted multiply.
// ============================================================================
//
//  channel | signals                                   | dir | transfer when
//  --------+-------------------------------------------+-----+----------------
//  input   | in_valid in_stall op use_const a_* b_*    | in  | valid & !stall
//  output  | out_valid out_stall res_real res_imag st. | out | valid & !stall
//  config  | cfg_valid cfg_ready cfg_index cfg_data    | in  | valid & ready
//
//  One item per cycle while in_stall is low. An item passes from input
//  transfer to output valid through one product stage, four sum/setup
//  stages, one division cell per quotient bit, and the output register.
//  Reset clears the stage valids, the output/skid valids and the config
//  registers (weight resets to 1.0). An output stall fills a one-entry skid
//  register; only when that is occupied does in_stall rise and the pipe hold.
//
`default_nettype none

module complex_elementwise_alu_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [3:0]                      op,
    input  wire logic                            use_const,
    input  wire logic signed [DATA_WIDTH-1:0]    a_real,
    input  wire logic signed [DATA_WIDTH-1:0]    a_imag,
    input  wire logic signed [DATA_WIDTH-1:0]    b_real,
    input  wire logic signed [DATA_WIDTH-1:0]    b_imag,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic signed [DATA_WIDTH-1:0]         res_real,
    output logic signed [DATA_WIDTH-1:0]         res_imag,
    output logic [1:0]                           status,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [cmpx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [DATA_WIDTH-1:0]           cfg_data
);

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W;
    localparam int NS = 5 + W;
    localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

    // ---------------- configuration registers ----------------
    logic                mode_reg;
    logic signed [W-1:0] creal_reg, cimag_reg, weight_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            creal_reg  <= '0;
            cimag_reg  <= '0;
            weight_reg <= W'(1) << FRAC_BITS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cmpx_pkg::CFG_MODE:   mode_reg   <= cfg_data[0];
                cmpx_pkg::CFG_CREAL:  creal_reg  <= cfg_data;
                cmpx_pkg::CFG_CIMAG:  cimag_reg  <= cfg_data;
                cmpx_pkg::CFG_WEIGHT: weight_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline advance and stage valids ----------------
    logic          en;
    logic [NS-1:0] v_reg;
    logic          skid_valid_reg, skid_valid_next;
    logic          out_valid_reg, out_valid_next;

    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NS-2:0], in_valid};
    end

    // ---------------- product stage ----------------
    cmpx_pkg::ctl_t       s1_ctl;
    logic signed [W-1:0]  s1_ar, s1_ai, s1_br, s1_bi;
    logic signed [PW-1:0] s1_m0, s1_m1, s1_m2, s1_m3, s1_m4, s1_m5;

    cmpx_mul_stage #(.W(W)) u_mul (
        .clk        (clk),
        .en         (en),
        .op         (op),
        .use_const  (use_const),
        .a_real     (a_real),
        .a_imag     (a_imag),
        .b_real     (b_real),
        .b_imag     (b_imag),
        .cmode      (mode_reg),
        .const_real (creal_reg),
        .const_imag (cimag_reg),
        .weight     (weight_reg),
        .ctl        (s1_ctl),
        .ar         (s1_ar),
        .ai         (s1_ai),
        .br         (s1_br),
        .bi         (s1_bi),
        .m0         (s1_m0),
        .m1         (s1_m1),
        .m2         (s1_m2),
        .m3         (s1_m3),
        .m4         (s1_m4),
        .m5         (s1_m5)
    );

    // ---------------- sums and divider setup ----------------
    logic [W-1:0]      c_real [0:W];
    logic [W-1:0]      c_imag [0:W];
    logic [1:0]        c_st   [0:W];
    cmpx_pkg::dflag_t  c_flag [0:W];
    logic [PW-1:0]     c_den  [0:W];
    logic [PW-1:0]     c_rr   [0:W];
    logic [PW-1:0]     c_ri   [0:W];
    logic [W-1:0]      c_qr   [0:W];
    logic [W-1:0]      c_qi   [0:W];

    cmpx_prep #(.W(W), .F(FRAC_BITS)) u_prep (
        .clk      (clk),
        .en       (en),
        .ctl      (s1_ctl),
        .ar       (s1_ar),
        .ai       (s1_ai),
        .br       (s1_br),
        .bi       (s1_bi),
        .m0       (s1_m0),
        .m1       (s1_m1),
        .m2       (s1_m2),
        .m3       (s1_m3),
        .m4       (s1_m4),
        .m5       (s1_m5),
        .byp_real (c_real[0]),
        .byp_imag (c_imag[0]),
        .byp_st   (c_st[0]),
        .dflag    (c_flag[0]),
        .den      (c_den[0]),
        .rem_r    (c_rr[0]),
        .rem_i    (c_ri[0]),
        .nq_r     (c_qr[0]),
        .nq_i     (c_qi[0])
    );

    // ---------------- row of division cells, one quotient bit each -------
    for (genvar k = 0; k < W; k++)
    begin : g_cell
        cmpx_div_cell #(.W(W)) u_cell (
            .clk         (clk),
            .en          (en),
            .byp_real_in (c_real[k]),
            .byp_imag_in (c_imag[k]),
            .byp_st_in   (c_st[k]),
            .dflag_in    (c_flag[k]),
            .den_in      (c_den[k]),
            .rem_r_in    (c_rr[k]),
            .rem_i_in    (c_ri[k]),
            .nq_r_in     (c_qr[k]),
            .nq_i_in     (c_qi[k]),
            .byp_real    (c_real[k+1]),
            .byp_imag    (c_imag[k+1]),
            .byp_st      (c_st[k+1]),
            .dflag       (c_flag[k+1]),
            .den         (c_den[k+1]),
            .rem_r       (c_rr[k+1]),
            .rem_i       (c_ri[k+1]),
            .nq_r        (c_qr[k+1]),
            .nq_i        (c_qi[k+1])
        );
    end

    // ---------------- quotient sign and clamp ----------------
    cmpx_pkg::dflag_t fl;
    logic [W-1:0]     qr, qi;
    logic             ovr, ovi;
    logic [W-1:0]     fin_real, fin_imag;
    logic [1:0]       fin_st;

    always_comb
    begin
        fl  = c_flag[W];
        qr  = c_qr[W];
        qi  = c_qi[W];
        // positive quotient must stay below 2^(W-1); negative may reach it
        ovr = fl.povf_r || (fl.neg_r ? (qr[W-1] && qr[W-2:0] != '0) : qr[W-1]);
        ovi = fl.povf_i || (fl.neg_i ? (qi[W-1] && qi[W-2:0] != '0) : qi[W-1]);
        if (fl.is_div)
        begin
            fin_real = ovr ? (fl.neg_r ? MINW : MAXW) : (fl.neg_r ? -qr : qr);
            fin_imag = ovi ? (fl.neg_i ? MINW : MAXW) : (fl.neg_i ? -qi : qi);
            fin_st   = (ovr || ovi) ? cmpx_pkg::ST_SAT : cmpx_pkg::ST_OK;
        end
        else
        begin
            fin_real = c_real[W];
            fin_imag = c_imag[W];
            fin_st   = c_st[W];
        end
    end

    // ---------------- output register with skid entry ----------------
    logic         lv;
    logic         out_load, skid_load, out_from_skid;
    logic [W-1:0] out_real_reg, out_imag_reg, skid_real_reg, skid_imag_reg;
    logic [1:0]   out_st_reg, skid_st_reg;

    always_comb
    begin
        lv              = v_reg[NS-1] && en;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_load        = 1'b0;
        skid_load       = 1'b0;
        out_from_skid   = 1'b0;
        if (skid_valid_reg)
        begin
            if (!out_stall)
            begin
                out_from_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_load       = lv;
            out_valid_next = lv;
        end
        else if (lv)
        begin
            skid_load       = 1'b1;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_from_skid)
        begin
            out_real_reg <= skid_real_reg;
            out_imag_reg <= skid_imag_reg;
            out_st_reg   <= skid_st_reg;
        end
        else if (out_load)
        begin
            out_real_reg <= fin_real;
            out_imag_reg <= fin_imag;
            out_st_reg   <= fin_st;
        end
        if (skid_load)
        begin
            skid_real_reg <= fin_real;
            skid_imag_reg <= fin_imag;
            skid_st_reg   <= fin_st;
        end
    end

    assign out_valid = out_valid_reg;
    assign res_real  = out_real_reg;
    assign res_imag  = out_imag_reg;
    assign status    = out_st_reg;

endmodule

`default_nettype wire

>>> hw/rtl/cmpx_mul_stage.sv
// ============================================================================
// cmpx_mul_stage
// Operand selection and the registered product stage.
// ============================================================================
`default_nettype none

module cmpx_mul_stage #(
    parameter int W = 32
) (
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic [3:0]            op,
    input  wire logic                  use_const,
    input  wire logic signed [W-1:0]   a_real,
    input  wire logic signed [W-1:0]   a_imag,
    input  wire logic signed [W-1:0]   b_real,
    input  wire logic signed [W-1:0]   b_imag,
    input  wire logic                  cmode,
    input  wire logic signed [W-1:0]   const_real,
    input  wire logic signed [W-1:0]   const_imag,
    input  wire logic signed [W-1:0]   weight,
    output cmpx_pkg::ctl_t             ctl,
    output logic signed [W-1:0]        ar,
    output logic signed [W-1:0]        ai,
    output logic signed [W-1:0]        br,
    output logic signed [W-1:0]        bi,
    output logic signed [2*W-1:0]      m0,
    output logic signed [2*W-1:0]      m1,
    output logic signed [2*W-1:0]      m2,
    output logic signed [2*W-1:0]      m3,
    output logic signed [2*W-1:0]      m4,
    output logic signed [2*W-1:0]      m5
);

    localparam int PW = 2 * W;

    logic signed [W-1:0]  ar_next, ai_next, br_next, bi_next;
    logic signed [W-1:0]  x0, x1, x2, x4;
    logic signed [PW-1:0] m0_next, m1_next, m2_next, m3_next, m4_next, m5_next;
    cmpx_pkg::ctl_t       ctl_next, ctl_reg;
    logic signed [W-1:0]  ar_reg, ai_reg, br_reg, bi_reg;
    logic signed [PW-1:0] m0_reg, m1_reg, m2_reg, m3_reg, m4_reg, m5_reg;

    // operand select: imaginary parts read as zero in real mode
    always_comb
    begin
        ar_next = a_real;
        ai_next = cmode ? a_imag : '0;
        br_next = use_const ? const_real : b_real;
        bi_next = cmode ? (use_const ? const_imag : b_imag) : '0;
        ctl_next.op    = op;
        ctl_next.cmode = cmode;
    end

    // multiplier inputs are shared between opcodes
    always_comb
    begin
        x0 = (op == cmpx_pkg::OP_MAGSQ) ? ar_next : br_next;
        x1 = (op == cmpx_pkg::OP_MAGSQ) ? ai_next : bi_next;
        x2 = (op == cmpx_pkg::OP_WMUL)  ? weight  : bi_next;
        x4 = (op == cmpx_pkg::OP_WADD)  ? weight  : br_next;
        m0_next = ar_next * x0;
        m1_next = ai_next * x1;
        m2_next = ar_next * x2;
        m3_next = ai_next * br_next;
        m4_next = x4 * br_next;
        m5_next = bi_next * bi_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg <= ctl_next;
            ar_reg  <= ar_next;
            ai_reg  <= ai_next;
            br_reg  <= br_next;
            bi_reg  <= bi_next;
            m0_reg  <= m0_next;
            m1_reg  <= m1_next;
            m2_reg  <= m2_next;
            m3_reg  <= m3_next;
            m4_reg  <= m4_next;
            m5_reg  <= m5_next;
        end
    end

    assign ctl = ctl_reg;
    assign ar  = ar_reg;
    assign ai  = ai_reg;
    assign br  = br_reg;
    assign bi  = bi_reg;
    assign m0  = m0_reg;
    assign m1  = m1_reg;
    assign m2  = m2_reg;
    assign m3  = m3_reg;
    assign m4  = m4_reg;
    assign m5  = m5_reg;

endmodule

`default_nettype wire

>>> hw/rtl/cmpx_prep.sv
// ============================================================================
// cmpx_prep
// Sums, truncation and saturation for the direct ops, the weighted multiply
// second product, and divider setup. Four register stages.
// ============================================================================
`default_nettype none

module cmpx_prep #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire cmpx_pkg::ctl_t        ctl,
    input  wire logic signed [W-1:0]   ar,
    input  wire logic signed [W-1:0]   ai,
    input  wire logic signed [W-1:0]   br,
    input  wire logic signed [W-1:0]   bi,
    input  wire logic signed [2*W-1:0] m0,
    input  wire logic signed [2*W-1:0] m1,
    input  wire logic signed [2*W-1:0] m2,
    input  wire logic signed [2*W-1:0] m3,
    input  wire logic signed [2*W-1:0] m4,
    input  wire logic signed [2*W-1:0] m5,
    output logic [W-1:0]               byp_real,
    output logic [W-1:0]               byp_imag,
    output logic [1:0]                 byp_st,
    output cmpx_pkg::dflag_t           dflag,
    output logic [2*W-1:0]             den,
    output logic [2*W-1:0]             rem_r,
    output logic [2*W-1:0]             rem_i,
    output logic [W-1:0]               nq_r,
    output logic [W-1:0]               nq_i
);

    localparam int PW = 2 * W;
    localparam int SW = PW + 1;
    localparam int AW = PW - F;
    localparam int HL = AW / 2;
    localparam int AH = AW - HL;
    localparam int XW = AW + W;
    localparam int LW = (XW > SW) ? XW : SW;
    localparam int CW = PW + F;
    localparam int DS = 1 + PW + W;

    localparam logic signed [LW-1:0] MAXV = LW'({(W-1){1'b1}});
    localparam logic signed [LW-1:0] MINV = ~MAXV;
    localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [1:0] {K_SAT, K_FIX, K_DIV, K_WMUL} kind_t;

    // truncate toward zero (optional) then clamp; returns {overflow, value}
    function automatic logic [W:0] trunc_sat(input logic signed [LW-1:0] x,
                                             input logic shf);
        logic signed [LW-1:0] bias;
        logic signed [LW-1:0] y;
        logic                 ovf;
        logic [W-1:0]         v;
        bias = (shf && x[LW-1]) ? $signed(LW'({F{1'b1}})) : '0;
        y    = x + bias;
        if (shf)
            y = y >>> F;
        ovf = 1'b1;
        if (y > MAXV)
            v = MAXW;
        else if (y < MINV)
            v = MINW;
        else
        begin
            ovf = 1'b0;
            v   = y[W-1:0];
        end
        return {ovf, v};
    endfunction

    // saturation by sign to the most negative or most positive value (zero stays zero), for divide by zero
    function automatic logic signed [W-1:0] sign_sat(input logic signed [W-1:0] v);
        logic signed [W-1:0] r;
        if (v[W-1])
            r = MINW;
        else if (v != '0)
            r = MAXW;
        else
            r = '0;
        return r;
    endfunction

    // magnitude, pre-shift, early overflow check; returns {povf, rem, nq}
    function automatic logic [DS-1:0] div_setup(input logic signed [SW-1:0] x,
                                                input logic [PW-1:0] d);
        logic signed [SW-1:0] m;
        logic [CW-1:0]        nf;
        logic [CW-1:0]        top;
        logic                 povf;
        m    = x[SW-1] ? -x : x;
        nf   = {m[PW-1:0], {F{1'b0}}};
        top  = nf >> W;
        povf = (top >= CW'(d));
        return {povf, top[PW-1:0], nf[W-1:0]};
    endfunction

    // ---------------- stage 2: sums and op decode ----------------
    kind_t                kind2_next, kind2_reg;
    logic [1:0]           st2_next, st2_reg;
    logic                 shf2_next, shf2_reg;
    logic signed [SW-1:0] xr2_next, xr2_reg, xi2_next, xi2_reg;
    logic [PW-1:0]        den2_next, den2_reg;
    logic signed [PW-1:0] awb;
    logic signed [AW-1:0] aw2_next, aw2_reg;
    logic signed [W-1:0]  br2_reg;
    logic signed [SW-1:0] e_ar;

    always_comb
    begin
        kind2_next = K_FIX;
        st2_next   = cmpx_pkg::ST_UNSUP;
        shf2_next  = 1'b0;
        xr2_next   = '0;
        xi2_next   = '0;
        e_ar       = SW'(ar);
        den2_next  = $unsigned(m4) + $unsigned(m5);
        awb        = (m2 + (m2[PW-1] ? $signed(PW'({F{1'b1}})) : $signed(PW'(0)))) >>> F;
        aw2_next   = awb[AW-1:0];
        case (ctl.op)
            cmpx_pkg::OP_ADD:
            begin
                kind2_next = K_SAT;
                xr2_next   = e_ar + SW'(br);
                xi2_next   = SW'(ai) + SW'(bi);
            end
            cmpx_pkg::OP_SUB:
            begin
                kind2_next = K_SAT;
                xr2_next   = e_ar - SW'(br);
                xi2_next   = SW'(ai) - SW'(bi);
            end
            cmpx_pkg::OP_MUL:
            begin
                kind2_next = K_SAT;
                shf2_next  = 1'b1;
                xr2_next   = SW'(m0) - SW'(m1);
                xi2_next   = SW'(m2) + SW'(m3);
            end
            cmpx_pkg::OP_DIV:
            begin
                if (br == '0 && bi == '0)
                begin
                    st2_next = cmpx_pkg::ST_DIV0;
                    xr2_next = SW'(sign_sat(ar));
                    xi2_next = SW'(sign_sat(ai));
                end
                else
                begin
                    kind2_next = K_DIV;
                    xr2_next   = SW'(m0) + SW'(m1);
                    xi2_next   = SW'(m3) - SW'(m2);
                end
            end
            cmpx_pkg::OP_MULCONJ:
            begin
                kind2_next = K_SAT;
                shf2_next  = 1'b1;
                xr2_next   = SW'(m0) + SW'(m1);
                xi2_next   = SW'(m2) - SW'(m3);
            end
            cmpx_pkg::OP_MAGSQ:
            begin
                kind2_next = K_SAT;
                shf2_next  = 1'b1;
                xr2_next   = SW'(m0) + SW'(m1);
            end
            cmpx_pkg::OP_ABS:
            begin
                if (!ctl.cmode)
                begin
                    kind2_next = K_SAT;
                    xr2_next   = ar[W-1] ? -e_ar : e_ar;
                end
            end
            cmpx_pkg::OP_CLIP:
            begin
                if (!ctl.cmode)
                begin
                    kind2_next = K_SAT;
                    xr2_next   = (!ar[W-1] && ar != '0) ? e_ar : '0;
                end
            end
            cmpx_pkg::OP_WADD:
            begin
                if (!ctl.cmode)
                begin
                    kind2_next = K_SAT;
                    shf2_next  = 1'b1;
                    xr2_next   = (e_ar <<< F) + SW'(m4);
                end
            end
            cmpx_pkg::OP_WMUL:
            begin
                if (!ctl.cmode)
                    kind2_next = K_WMUL;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind2_reg <= kind2_next;
            st2_reg   <= st2_next;
            shf2_reg  <= shf2_next;
            xr2_reg   <= xr2_next;
            xi2_reg   <= xi2_next;
            den2_reg  <= den2_next;
            aw2_reg   <= aw2_next;
            br2_reg   <= br;
        end
    end

    // ---------------- stage 3: finish direct ops, divider setup ----------
    logic [W:0]              tr, ti;
    logic [DS-1:0]           dr, di;
    kind_t                   kind3_reg;
    logic [W-1:0]            rr3_next, rr3_reg, ri3_next, ri3_reg;
    logic [1:0]              st3_next, st3_reg;
    logic                    neg_r3_reg, neg_i3_reg;
    logic [DS-1:0]           dr3_reg, di3_reg;
    logic [PW-1:0]           den3_reg;
    logic signed [HL+W:0]    pl3_next, pl3_reg;
    logic signed [AH+W-1:0]  ph3_next, ph3_reg;

    always_comb
    begin
        tr = trunc_sat(LW'(xr2_reg), shf2_reg);
        ti = trunc_sat(LW'(xi2_reg), shf2_reg);
        dr = div_setup(xr2_reg, den2_reg);
        di = div_setup(xi2_reg, den2_reg);
        pl3_next = $signed({1'b0, aw2_reg[HL-1:0]}) * br2_reg;
        ph3_next = $signed(aw2_reg[AW-1:HL]) * br2_reg;
        case (kind2_reg)
            K_SAT:
            begin
                rr3_next = tr[W-1:0];
                ri3_next = ti[W-1:0];
                st3_next = (tr[W] || ti[W]) ? cmpx_pkg::ST_SAT : cmpx_pkg::ST_OK;
            end
            K_FIX:
            begin
                rr3_next = xr2_reg[W-1:0];
                ri3_next = xi2_reg[W-1:0];
                st3_next = st2_reg;
            end
            default:
            begin
                rr3_next = '0;
                ri3_next = '0;
                st3_next = cmpx_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind3_reg  <= kind2_reg;
            rr3_reg    <= rr3_next;
            ri3_reg    <= ri3_next;
            st3_reg    <= st3_next;
            neg_r3_reg <= xr2_reg[SW-1];
            neg_i3_reg <= xi2_reg[SW-1];
            dr3_reg    <= dr;
            di3_reg    <= di;
            den3_reg   <= den2_reg;
            pl3_reg    <= pl3_next;
            ph3_reg    <= ph3_next;
        end
    end

    // ---------------- stage 4: weighted multiply partial sum -------------
    logic signed [XW-1:0] x4_next, x4_reg;
    kind_t                kind4_reg;
    logic [W-1:0]         rr4_reg, ri4_reg;
    logic [1:0]           st4_reg;
    logic                 neg_r4_reg, neg_i4_reg;
    logic [DS-1:0]        dr4_reg, di4_reg;
    logic [PW-1:0]        den4_reg;

    assign x4_next = (XW'(ph3_reg) <<< HL) + XW'(pl3_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x4_reg     <= x4_next;
            kind4_reg  <= kind3_reg;
            rr4_reg    <= rr3_reg;
            ri4_reg    <= ri3_reg;
            st4_reg    <= st3_reg;
            neg_r4_reg <= neg_r3_reg;
            neg_i4_reg <= neg_i3_reg;
            dr4_reg    <= dr3_reg;
            di4_reg    <= di3_reg;
            den4_reg   <= den3_reg;
        end
    end

    // ---------------- stage 5: weighted multiply truncate and clamp ------
    logic [W:0]        tw;
    logic [W-1:0]      rr5_next, rr5_reg, ri5_next, ri5_reg;
    logic [1:0]        st5_next, st5_reg;
    cmpx_pkg::dflag_t  fl5_next, fl5_reg;
    logic [DS-1:0]     dr5_reg, di5_reg;
    logic [PW-1:0]     den5_reg;

    always_comb
    begin
        tw       = trunc_sat(LW'(x4_reg), 1'b1);
        rr5_next = rr4_reg;
        ri5_next = ri4_reg;
        st5_next = st4_reg;
        if (kind4_reg == K_WMUL)
        begin
            rr5_next = tw[W-1:0];
            ri5_next = '0;
            st5_next = tw[W] ? cmpx_pkg::ST_SAT : cmpx_pkg::ST_OK;
        end
        fl5_next.is_div = (kind4_reg == K_DIV);
        fl5_next.neg_r  = neg_r4_reg;
        fl5_next.neg_i  = neg_i4_reg;
        fl5_next.povf_r = dr4_reg[DS-1];
        fl5_next.povf_i = di4_reg[DS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rr5_reg  <= rr5_next;
            ri5_reg  <= ri5_next;
            st5_reg  <= st5_next;
            fl5_reg  <= fl5_next;
            dr5_reg  <= dr4_reg;
            di5_reg  <= di4_reg;
            den5_reg <= den4_reg;
        end
    end

    assign byp_real = rr5_reg;
    assign byp_imag = ri5_reg;
    assign byp_st   = st5_reg;
    assign dflag    = fl5_reg;
    assign den      = den5_reg;
    assign rem_r    = dr5_reg[DS-2:W];
    assign rem_i    = di5_reg[DS-2:W];
    assign nq_r     = dr5_reg[W-1:0];
    assign nq_i     = di5_reg[W-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/cmpx_div_cell.sv
// ============================================================================
// cmpx_div_cell
// One restoring-division step for both quotient components, plus the
// registered hand-off of the item's bypass result to the next cell.
// ============================================================================
`default_nettype none

module cmpx_div_cell #(
    parameter int W = 32
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [W-1:0]     byp_real_in,
    input  wire logic [W-1:0]     byp_imag_in,
    input  wire logic [1:0]       byp_st_in,
    input  wire cmpx_pkg::dflag_t dflag_in,
    input  wire logic [2*W-1:0]   den_in,
    input  wire logic [2*W-1:0]   rem_r_in,
    input  wire logic [2*W-1:0]   rem_i_in,
    input  wire logic [W-1:0]     nq_r_in,
    input  wire logic [W-1:0]     nq_i_in,
    output logic [W-1:0]          byp_real,
    output logic [W-1:0]          byp_imag,
    output logic [1:0]            byp_st,
    output cmpx_pkg::dflag_t      dflag,
    output logic [2*W-1:0]        den,
    output logic [2*W-1:0]        rem_r,
    output logic [2*W-1:0]        rem_i,
    output logic [W-1:0]          nq_r,
    output logic [W-1:0]          nq_i
);

    localparam int PW = 2 * W;

    // shift in the next numerator bit, subtract if it fits; the quotient bit
    // enters at the bottom of nq as the numerator bit leaves the top
    function automatic logic [PW+W-1:0] step(input logic [PW-1:0] rem,
                                             input logic [W-1:0] nq,
                                             input logic [PW-1:0] d);
        logic [PW:0] t;
        logic [PW:0] diff;
        logic        ge;
        t    = {rem, nq[W-1]};
        diff = t - {1'b0, d};
        ge   = (t >= {1'b0, d});
        return {(ge ? diff[PW-1:0] : t[PW-1:0]), nq[W-2:0], ge};
    endfunction

    logic [PW+W-1:0]   sr_next, si_next;
    logic [W-1:0]      byp_real_reg, byp_imag_reg;
    logic [1:0]        byp_st_reg;
    cmpx_pkg::dflag_t  dflag_reg;
    logic [PW-1:0]     den_reg;
    logic [PW+W-1:0]   sr_reg, si_reg;

    always_comb
    begin
        sr_next = step(rem_r_in, nq_r_in, den_in);
        si_next = step(rem_i_in, nq_i_in, den_in);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            byp_real_reg <= byp_real_in;
            byp_imag_reg <= byp_imag_in;
            byp_st_reg   <= byp_st_in;
            dflag_reg    <= dflag_in;
            den_reg      <= den_in;
            sr_reg       <= sr_next;
            si_reg       <= si_next;
        end
    end

    assign byp_real = byp_real_reg;
    assign byp_imag = byp_imag_reg;
    assign byp_st   = byp_st_reg;
    assign dflag    = dflag_reg;
    assign den      = den_reg;
    assign rem_r    = sr_reg[PW+W-1:W];
    assign rem_i    = si_reg[PW+W-1:W];
    assign nq_r     = sr_reg[W-1:0];
    assign nq_i     = si_reg[W-1:0];

endmodule

`default_nettype wire
